>>> src/sfs_pkg.sv
`default_nettype none

package sfs_pkg;

    // defaults for the top-level parameters
    localparam int MAX_FRAMES_DEF    = 64;
    localparam int DURATION_BITS_DEF = 24;

    // fixed widths
    localparam int ELAPSED_W  = 32;               // Q24.8 elapsed time
    localparam int FRAC_W     = 8;
    localparam int REM_W      = ELAPSED_W - FRAC_W; // whole frame steps in one tick
    localparam int RAW_W      = REM_W + 1;          // event count before saturation
    localparam int CALC_W     = 9;                  // signed frame arithmetic
    localparam int NF_W       = 7;
    localparam int RATE_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int EVENT_MAX  = 255;

    typedef enum logic [2:0] {
        REQ_TICK      = 3'd0,
        REQ_LOAD      = 3'd1,
        REQ_SET_FRAME = 3'd2,
        REQ_RESET     = 3'd3,
        REQ_PAUSE     = 3'd4
    } sfs_op_t;

    localparam logic [1:0] MODE_KEEP  = 2'd0;
    localparam logic [1:0] MODE_PLAY  = 2'd1;
    localparam logic [1:0] MODE_PAUSE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_FRAMES = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAY_RATE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUNCE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE    = 3'd4;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [15:0] delta_time;
        logic [5:0]  frame_index;
        logic [23:0] frame_duration;
        logic [1:0]  reset_mode;
        logic        pause_flag;
    } sfs_req_t;

    typedef struct packed {
        logic [5:0] current_frame;
        logic       finished;
        logic       bouncing;
        logic       paused;
        logic [7:0] end_events;
        logic       frame_changed;
    } sfs_result_t;

    typedef struct packed {
        logic lookup;
        logic write;
    } sfs_trail_ctl_t;

    typedef struct packed {
        logic valid;
        logic hit;
    } sfs_trail_rsp_t;

    typedef struct packed {
        logic signed [CALC_W-1:0] frame;
        logic                     bp;
        logic                     fm;
        logic                     ev;
    } sfs_adv_t;

    localparam logic signed [CALC_W-1:0] ZERO_S = 9'sd0;
    localparam logic signed [CALC_W-1:0] ONE_S  = 9'sd1;
    localparam logic signed [CALC_W-1:0] TWO_S  = 9'sd2;

    // one frame step; ev flags an end or wrap event
    function automatic sfs_adv_t sfs_advance(
        input logic signed [CALC_W-1:0] frame,
        input logic                     bp,
        input logic                     fm,
        input logic signed [CALC_W-1:0] nf,
        input logic                     loop_en,
        input logic                     bounce_en,
        input logic                     reverse_en
    );
        sfs_adv_t                 r;
        logic signed [CALC_W-1:0] nx;
        r.bp = bp;
        r.fm = fm;
        r.ev = 1'b0;
        nx   = (reverse_en ^ bp) ? (frame - ONE_S) : (frame + ONE_S);
        if (!reverse_en)
        begin
            if (nx < ZERO_S)
            begin
                r.ev = ~fm;
                if (loop_en)
                begin
                    r.bp = 1'b0;
                    nx   = ONE_S;
                end
                else
                begin
                    r.fm = 1'b1;
                    nx   = ZERO_S;
                end
            end
            else if (nx >= nf)
            begin
                if (bounce_en)
                begin
                    r.bp = 1'b1;
                    nx   = nf - TWO_S;
                end
                else
                begin
                    r.ev = ~fm;
                    if (loop_en)
                    begin
                        nx = ZERO_S;
                    end
                    else
                    begin
                        r.fm = 1'b1;
                        nx   = nf - ONE_S;
                    end
                end
            end
        end
        else
        begin
            if (nx < ZERO_S)
            begin
                if (bounce_en)
                begin
                    r.bp = 1'b1;
                    nx   = ONE_S;
                end
                else
                begin
                    r.ev = ~fm;
                    if (loop_en)
                    begin
                        nx = nf - ONE_S;
                    end
                    else
                    begin
                        r.fm = 1'b1;
                        nx   = ZERO_S;
                    end
                end
            end
            else if (nx >= nf)
            begin
                r.ev = ~fm;
                if (loop_en)
                begin
                    r.bp = 1'b0;
                    nx   = nf - TWO_S;
                end
                else
                begin
                    r.fm = 1'b1;
                    nx   = nf - ONE_S;
                end
            end
        end
        if (nx >= nf)
        begin
            nx = nf - ONE_S;
        end
        if (nx < ZERO_S)
        begin
            nx = ZERO_S;
        end
        r.frame = nx;
        return r;
    endfunction

endpackage

`default_nettype wire

>>> src/sfs_div.sv
`default_nettype none

// restoring divider, one quotient bit per cycle
module sfs_div #(
    parameter int DIVISOR_W = sfs_pkg::DURATION_BITS_DEF + sfs_pkg::FRAC_W
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [sfs_pkg::ELAPSED_W-1:0]  dividend,
    input  wire logic [DIVISOR_W-1:0]           divisor,
    output logic                                done,
    output logic      [sfs_pkg::ELAPSED_W-1:0]  quotient,
    output logic      [DIVISOR_W-1:0]           remainder
);

    localparam int DD_W  = sfs_pkg::ELAPSED_W;
    localparam int CNT_W = $clog2(DD_W + 1);

    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DD_W-1:0]  quo_reg, quo_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIVISOR_W-1:0] dvs_reg, dvs_next;
    logic [DIVISOR_W:0]   shifted;
    logic [DIVISOR_W:0]   diff;
    logic                 ge;

    assign shifted = {rem_reg, quo_reg[DD_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign ge      = (shifted >= {1'b0, dvs_reg});

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = CNT_W'(DD_W);
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
        end
        else if (run_reg)
        begin
            quo_next = {quo_reg[DD_W-2:0], ge};
            rem_next = ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

>>> src/sfs_trail.sv
`default_nettype none

// visited-state store for cycle detection within one tick.
// seen memory: key -> {step count, events}; trail memory: step -> key.
// an entry is live only if both agree, so nothing is cleared between ticks.
module sfs_trail #(
    parameter int KEY_SPACE = 4 * sfs_pkg::MAX_FRAMES_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire sfs_pkg::sfs_trail_ctl_t          ctl,
    input  wire logic [$clog2(KEY_SPACE)-1:0]     key,
    input  wire logic [$clog2(KEY_SPACE+1)-1:0]   cnt,
    input  wire logic [$clog2(KEY_SPACE+1)-1:0]   raw_lo,
    output sfs_pkg::sfs_trail_rsp_t               rsp,
    output logic      [$clog2(KEY_SPACE+1)-1:0]   s_done,
    output logic      [$clog2(KEY_SPACE+1)-1:0]   s_raw
);

    localparam int KEY_W  = $clog2(KEY_SPACE);
    localparam int DONE_W = $clog2(KEY_SPACE + 1);

    logic [2*DONE_W-1:0] seen_mem  [KEY_SPACE];
    logic [KEY_W-1:0]    trail_mem [KEY_SPACE];

    logic [2*DONE_W-1:0] seen_q;
    logic [KEY_W-1:0]    trail_q;
    logic                lk1_reg, lk2_reg;
    logic [KEY_W-1:0]    key1_reg, key2_reg;
    logic [DONE_W-1:0]   cnt1_reg;
    logic [DONE_W-1:0]   s_done2_reg, s_raw2_reg;
    logic                lt2_reg;
    logic [DONE_W-1:0]   seen_done;

    assign seen_done = seen_q[2*DONE_W-1:DONE_W];

    always_ff @(posedge clk)
    begin
        if (ctl.write)
        begin
            seen_mem[key]                <= {cnt, raw_lo};
            trail_mem[cnt[KEY_W-1:0]]    <= key;
        end
        if (ctl.lookup)
        begin
            seen_q <= seen_mem[key];
        end
        if (lk1_reg)
        begin
            trail_q <= trail_mem[seen_done[KEY_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lk1_reg <= 1'b0;
            lk2_reg <= 1'b0;
        end
        else
        begin
            lk1_reg <= ctl.lookup;
            lk2_reg <= lk1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        key1_reg    <= key;
        cnt1_reg    <= cnt;
        key2_reg    <= key1_reg;
        s_done2_reg <= seen_done;
        s_raw2_reg  <= seen_q[DONE_W-1:0];
        lt2_reg     <= (seen_done < cnt1_reg);
    end

    assign rsp.valid = lk2_reg;
    assign rsp.hit   = lt2_reg && (trail_q == key2_reg);
    assign s_done    = s_done2_reg;
    assign s_raw     = s_raw2_reg;

endmodule

`default_nettype wire

>>> src/sprite_frame_sequencer_unit.sv
`default_nettype none

// Sprite frame sequencer for one animation.
//
//   channel   | ports                                   | handshake
//   ----------+-----------------------------------------+---------------------------
//   request   | start, busy, req                        | word taken when start & !busy
//   result    | done, result                            | one-cycle strobe, no stall
//   config    | cfg_valid, cfg_ready, cfg_index, cfg_data| word taken when valid & ready
//
// Flow: load, set frame, reset, pause and unused codes go from idle straight to
// the report; a tick that holds its frame passes the compare state first. A tick
// that steps frames adds a division of the elapsed time by the frame duration,
// then a lookup and a wait per new animation state (two reads through the trail
// memories), at most 4*MAX_FRAMES of them, a second division and an event add
// when a repeating cycle is found, and one step per cycle for the steps left over.
// Reset clears control state; the duration table holds garbage until loaded.
// busy drops in the cycle done is shown, so the next word may be taken then.
// The result side cannot stall; cfg_ready is always high.
module sprite_frame_sequencer_unit #(
    parameter int MAX_FRAMES    = sfs_pkg::MAX_FRAMES_DEF,
    parameter int DURATION_BITS = sfs_pkg::DURATION_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire sfs_pkg::sfs_req_t                 req,
    output logic                                   done,
    output sfs_pkg::sfs_result_t                   result,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [sfs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [sfs_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int FW        = $clog2(MAX_FRAMES);
    localparam int KEY_SPACE = 4 * MAX_FRAMES;
    localparam int KEY_W     = $clog2(KEY_SPACE);
    localparam int DONE_W    = $clog2(KEY_SPACE + 1);
    localparam int DVW       = DURATION_BITS + sfs_pkg::FRAC_W;
    localparam int CMP_W     = (DVW > sfs_pkg::ELAPSED_W) ? DVW : sfs_pkg::ELAPSED_W;
    localparam int EL_W      = sfs_pkg::ELAPSED_W;
    localparam int REM_W     = sfs_pkg::REM_W;
    localparam int RAW_W     = sfs_pkg::RAW_W;
    localparam int NF_W      = sfs_pkg::NF_W;
    localparam int PROD_W    = REM_W + DONE_W;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_TCMP   = 8'b0000_0010,  // elapsed + increment against duration
        S_DIV1   = 8'b0000_0100,  // elapsed / duration
        S_LOOK   = 8'b0000_1000,  // next step or trail lookup
        S_WAIT   = 8'b0001_0000,  // trail read in flight
        S_DIV2   = 8'b0010_0000,  // steps left / cycle length
        S_MULR   = 8'b0100_0000,  // add events of skipped cycles
        S_REPORT = 8'b1000_0000
    } sfs_state_t;

    sfs_state_t state_reg, state_next;

    // configuration
    logic [NF_W-1:0]            num_frames_reg, num_frames_next;
    logic [sfs_pkg::RATE_W-1:0] play_rate_reg, play_rate_next;
    logic                       loop_reg, loop_next;
    logic                       bounce_reg, bounce_next;
    logic                       reverse_reg, reverse_next;

    // animation state
    logic [FW-1:0]   frame_reg, frame_next;
    logic [EL_W-1:0] elapsed_reg, elapsed_next;
    logic            fm_reg, fm_next;
    logic            bp_reg, bp_next;
    logic            pause_reg, pause_next;

    // tick working registers
    logic [FW-1:0]     before_reg, before_next;
    logic [EL_W-1:0]   inc_reg, inc_next;
    logic [REM_W-1:0]  remaining_reg, remaining_next;
    logic [DONE_W-1:0] steps_reg, steps_next;
    logic [RAW_W-1:0]  raw_reg, raw_next;
    logic              skipped_reg, skipped_next;
    logic [DONE_W-1:0] cev_reg, cev_next;
    logic [PROD_W-1:0] prod_reg, prod_next;

    logic                 done_reg, done_next;
    sfs_pkg::sfs_result_t result_reg, result_next;

    // duration table
    logic [DURATION_BITS-1:0] dur_mem [MAX_FRAMES];
    logic [DURATION_BITS-1:0] dur_q;
    logic                     dur_rd, dur_we;

    logic              accept;
    logic [NF_W-1:0]   nf;
    logic [NF_W-1:0]   reset_target;
    logic [EL_W-1:0]   inc_prod;
    logic [EL_W:0]     el_sum;
    logic [EL_W-1:0]   el_sat;
    logic [DVW-1:0]    dfix;
    logic              hold;
    logic [KEY_W-1:0]  key;
    sfs_pkg::sfs_adv_t adv;
    logic [DONE_W-1:0] per;
    logic [PROD_W-1:0] prod_calc;

    sfs_pkg::sfs_trail_ctl_t trail_ctl;
    sfs_pkg::sfs_trail_rsp_t trail_rsp;
    logic [DONE_W-1:0]       trail_s_done, trail_s_raw;

    logic             div_start, div_done;
    logic [EL_W-1:0]  div_dividend, div_quo;
    logic [DVW-1:0]   div_divisor, div_rem;

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = result_reg;

    assign nf           = (num_frames_reg < MAX_FRAMES) ? num_frames_reg : NF_W'(MAX_FRAMES);
    assign reset_target = (reverse_reg && (nf != '0)) ? (nf - NF_W'(1)) : '0;

    // Q8.8 rate times whole time units gives Q.8 directly
    assign inc_prod = req.delta_time * play_rate_reg;
    assign el_sum   = {1'b0, elapsed_reg} + {1'b0, inc_reg};
    assign el_sat   = el_sum[EL_W] ? '1 : el_sum[EL_W-1:0];
    assign dfix     = {dur_q, {sfs_pkg::FRAC_W{1'b0}}};
    assign hold     = (dur_q == '0) || (CMP_W'(el_sat) < CMP_W'(dfix));

    assign key = {frame_reg, bp_reg, fm_reg};
    assign adv = sfs_pkg::sfs_advance(sfs_pkg::CALC_W'(frame_reg), bp_reg, fm_reg,
                                      sfs_pkg::CALC_W'(nf), loop_reg, bounce_reg,
                                      reverse_reg);

    assign per          = steps_reg - trail_s_done;
    assign div_dividend = (state_reg == S_TCMP) ? el_sat : EL_W'(remaining_reg);
    assign div_divisor  = (state_reg == S_TCMP) ? dfix : DVW'(per);
    assign prod_calc    = div_quo[REM_W-1:0] * cev_reg;

    always_comb
    begin
        state_next      = state_reg;
        num_frames_next = num_frames_reg;
        play_rate_next  = play_rate_reg;
        loop_next       = loop_reg;
        bounce_next     = bounce_reg;
        reverse_next    = reverse_reg;
        frame_next      = frame_reg;
        elapsed_next    = elapsed_reg;
        fm_next         = fm_reg;
        bp_next         = bp_reg;
        pause_next      = pause_reg;
        before_next     = before_reg;
        inc_next        = inc_reg;
        remaining_next  = remaining_reg;
        steps_next      = steps_reg;
        raw_next        = raw_reg;
        skipped_next    = skipped_reg;
        cev_next        = cev_reg;
        prod_next       = prod_reg;
        done_next       = 1'b0;
        result_next     = result_reg;
        dur_rd          = 1'b0;
        dur_we          = 1'b0;
        trail_ctl       = '0;
        div_start       = 1'b0;

        // config words must arrive only while idle; the block does not enforce this
        if (cfg_valid)
        begin
            unique case (cfg_index)
                sfs_pkg::CFG_NUM_FRAMES: num_frames_next = cfg_data[NF_W-1:0];
                sfs_pkg::CFG_PLAY_RATE:  play_rate_next  = cfg_data;
                sfs_pkg::CFG_LOOP:
                begin
                    loop_next = cfg_data[0];
                    if (cfg_data[0])
                    begin
                        fm_next = 1'b0;
                    end
                end
                sfs_pkg::CFG_BOUNCE:     bounce_next  = cfg_data[0];
                sfs_pkg::CFG_REVERSE:    reverse_next = cfg_data[0];
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    before_next = frame_reg;
                    raw_next    = '0;
                    state_next  = S_REPORT;
                    unique case (req.req_type)
                        sfs_pkg::REQ_TICK:
                        begin
                            inc_next   = pause_reg ? '0 : inc_prod;
                            dur_rd     = 1'b1;
                            state_next = S_TCMP;
                        end
                        sfs_pkg::REQ_LOAD:
                        begin
                            dur_we = (req.frame_index < MAX_FRAMES);
                        end
                        sfs_pkg::REQ_SET_FRAME:
                        begin
                            if (NF_W'(req.frame_index) < nf)
                            begin
                                elapsed_next = '0;
                                frame_next   = FW'(req.frame_index);
                            end
                        end
                        sfs_pkg::REQ_RESET:
                        begin
                            bp_next = 1'b0;
                            fm_next = 1'b0;
                            if (reset_target < nf)
                            begin
                                elapsed_next = '0;
                                frame_next   = FW'(reset_target);
                            end
                            if (req.reset_mode == sfs_pkg::MODE_PLAY)
                            begin
                                pause_next = 1'b0;
                            end
                            else if (req.reset_mode == sfs_pkg::MODE_PAUSE)
                            begin
                                pause_next = 1'b1;
                            end
                        end
                        sfs_pkg::REQ_PAUSE:
                        begin
                            if (pause_reg != req.pause_flag)
                            begin
                                pause_next = req.pause_flag;
                                if (!req.pause_flag)
                                begin
                                    fm_next = 1'b0;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end

            S_TCMP:
            begin
                if (hold)
                begin
                    elapsed_next = el_sat;
                    state_next   = S_REPORT;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV1;
                end
            end

            S_DIV1:
            begin
                if (div_done)
                begin
                    elapsed_next   = EL_W'(div_rem);
                    remaining_next = div_quo[REM_W-1:0];
                    steps_next     = '0;
                    skipped_next   = 1'b0;
                    state_next     = S_LOOK;
                end
            end

            S_LOOK:
            begin
                if (remaining_reg == '0)
                begin
                    state_next = S_REPORT;
                end
                else if (skipped_reg)
                begin
                    frame_next     = FW'(adv.frame);
                    bp_next        = adv.bp;
                    fm_next        = adv.fm;
                    raw_next       = raw_reg + RAW_W'(adv.ev);
                    remaining_next = remaining_reg - REM_W'(1);
                end
                else
                begin
                    trail_ctl.lookup = 1'b1;
                    state_next       = S_WAIT;
                end
            end

            S_WAIT:
            begin
                if (trail_rsp.valid)
                begin
                    if (trail_rsp.hit)
                    begin
                        // state seen before: the path repeats with period per
                        cev_next   = DONE_W'(raw_reg) - trail_s_raw;
                        div_start  = 1'b1;
                        state_next = S_DIV2;
                    end
                    else
                    begin
                        trail_ctl.write = 1'b1;
                        frame_next      = FW'(adv.frame);
                        bp_next         = adv.bp;
                        fm_next         = adv.fm;
                        raw_next        = raw_reg + RAW_W'(adv.ev);
                        steps_next      = steps_reg + DONE_W'(1);
                        remaining_next  = remaining_reg - REM_W'(1);
                        state_next      = S_LOOK;
                    end
                end
            end

            S_DIV2:
            begin
                if (div_done)
                begin
                    prod_next      = prod_calc;
                    remaining_next = REM_W'(div_rem);
                    skipped_next   = 1'b1;
                    state_next     = S_MULR;
                end
            end

            S_MULR:
            begin
                raw_next   = RAW_W'(raw_reg + prod_reg);
                state_next = S_LOOK;
            end

            S_REPORT:
            begin
                done_next                 = 1'b1;
                result_next.current_frame = 6'(frame_reg);
                result_next.finished      = fm_reg;
                result_next.bouncing      = bp_reg;
                result_next.paused        = pause_reg;
                result_next.end_events    = (raw_reg > RAW_W'(sfs_pkg::EVENT_MAX))
                                            ? 8'(sfs_pkg::EVENT_MAX) : raw_reg[7:0];
                result_next.frame_changed = (frame_reg != before_reg);
                state_next                = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            num_frames_reg <= NF_W'(1);
            play_rate_reg  <= sfs_pkg::RATE_W'(256);
            loop_reg       <= 1'b0;
            bounce_reg     <= 1'b0;
            reverse_reg    <= 1'b0;
            frame_reg      <= '0;
            elapsed_reg    <= '0;
            fm_reg         <= 1'b0;
            bp_reg         <= 1'b0;
            pause_reg      <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            num_frames_reg <= num_frames_next;
            play_rate_reg  <= play_rate_next;
            loop_reg       <= loop_next;
            bounce_reg     <= bounce_next;
            reverse_reg    <= reverse_next;
            frame_reg      <= frame_next;
            elapsed_reg    <= elapsed_next;
            fm_reg         <= fm_next;
            bp_reg         <= bp_next;
            pause_reg      <= pause_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        before_reg    <= before_next;
        inc_reg       <= inc_next;
        remaining_reg <= remaining_next;
        steps_reg     <= steps_next;
        raw_reg       <= raw_next;
        skipped_reg   <= skipped_next;
        cev_reg       <= cev_next;
        prod_reg      <= prod_next;
        result_reg    <= result_next;
    end

    // duration table, read at the frame current when the tick begins
    always_ff @(posedge clk)
    begin
        if (dur_we)
        begin
            dur_mem[FW'(req.frame_index)] <= DURATION_BITS'(req.frame_duration);
        end
        if (dur_rd)
        begin
            dur_q <= dur_mem[frame_reg];
        end
    end

    sfs_trail #(
        .KEY_SPACE (KEY_SPACE)
    ) u_trail (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (trail_ctl),
        .key    (key),
        .cnt    (steps_reg),
        .raw_lo (DONE_W'(raw_reg)),
        .rsp    (trail_rsp),
        .s_done (trail_s_done),
        .s_raw  (trail_s_raw)
    );

    sfs_div #(
        .DIVISOR_W (DVW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

endmodule

`default_nettype wire

>>> test/sprite_frame_sequencer_unit_test.sv
`default_nettype none

// Sprite frame sequencer testbench.
// A queue of request words feeds a clocked driver that sends them in bursts
// with random gaps. Every word taken by the block is run through a local
// model of the sequencer, and the display it should produce is queued.
// A clocked monitor checks each done strobe against the oldest queued display.
// The register settings change between phases, only once the block has
// gone quiet.
module sprite_frame_sequencer_unit_test;
    import sfs_pkg::*;

    localparam int FRAME_SLOTS       = MAX_FRAMES_DEF;
    localparam int STATE_KEYS        = FRAME_SLOTS * 4;   // frame x bounce x finished
    localparam int REQ_CODES         = 8;                 // 3-bit request field
    localparam logic [1:0] MODE_SPARE = 2'd3;             // undefined mode, keeps pause
    localparam int WORDS_PER_SETTING = 130;
    localparam int SETTING_COUNT     = 14;
    localparam int REPORT_MAX        = 25;
    // worst tick is a full state walk plus two divisions;
    // about 1900 words of that, plus gaps, taken a few times over
    localparam int CYCLE_LIMIT       = 8_000_000;

    // ------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  start     = 1'b0;
    logic                  busy;
    sfs_req_t              req_word  = '0;
    logic                  done;
    sfs_result_t           res_word;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sprite_frame_sequencer_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req_word),
        .done      (done),
        .result    (res_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Local copy of the sequencer state and its registers
    // ------------------------------------------------------------------
    logic [5:0]  shown_frame = '0;
    logic [31:0] time_acc    = '0;      // Q24.8 time units
    logic [23:0] frame_len [FRAME_SLOTS];
    logic        at_end      = 1'b0;    // finished, sticky
    logic        back_phase  = 1'b0;    // return leg of a bounce
    logic        held        = 1'b0;    // paused

    logic [6:0]  cfg_frames  = 7'd1;
    logic [15:0] cfg_rate    = 16'd256;
    logic        cfg_loop    = 1'b0;
    logic        cfg_bounce  = 1'b0;
    logic        cfg_reverse = 1'b0;

    sfs_req_t    queued_words [$];
    sfs_result_t expected_displays [$];

    int gap_left      = 0;
    int burst_left    = 0;
    int failures      = 0;
    int reports       = 0;
    int words_sent    = 0;
    int displays_seen = 0;
    int events_total  = 0;
    int settings_used = 0;
    int cycle_count   = 0;

    function automatic int frames_used();
        return (cfg_frames < FRAME_SLOTS) ? int'(cfg_frames) : FRAME_SLOTS;
    endfunction

    // One frame step; returns 1 when it raises an end or wrap event.
    function automatic logic step_one_frame();
        int   nf;
        int   nx;
        logic ev;
        nf = frames_used();
        nx = int'(shown_frame);
        ev = 1'b0;
        if (!cfg_reverse)
        begin
            nx += back_phase ? -1 : 1;
            if (nx < 0)
            begin
                ev = !at_end;
                if (cfg_loop)
                begin
                    back_phase = 1'b0;
                    nx         = 1;
                end
                else
                begin
                    at_end = 1'b1;
                    nx     = 0;
                end
            end
            else if (nx >= nf)
            begin
                if (cfg_bounce)
                begin
                    back_phase = 1'b1;
                    nx         = nf - 2;
                end
                else
                begin
                    ev = !at_end;
                    if (cfg_loop)
                    begin
                        nx = 0;
                    end
                    else
                    begin
                        at_end = 1'b1;
                        nx     = nf - 1;
                    end
                end
            end
        end
        else
        begin
            nx += back_phase ? 1 : -1;
            if (nx < 0)
            begin
                if (cfg_bounce)
                begin
                    back_phase = 1'b1;
                    nx         = 1;
                end
                else
                begin
                    ev = !at_end;
                    if (cfg_loop)
                    begin
                        nx = nf - 1;
                    end
                    else
                    begin
                        at_end = 1'b1;
                        nx     = 0;
                    end
                end
            end
            else if (nx >= nf)
            begin
                ev = !at_end;
                if (cfg_loop)
                begin
                    back_phase = 1'b0;
                    nx         = nf - 2;
                end
                else
                begin
                    at_end = 1'b1;
                    nx     = nf - 1;
                end
            end
        end
        if (nx >= nf)
        begin
            nx = nf - 1;
        end
        if (nx < 0)
        begin
            nx = 0;
        end
        shown_frame = 6'(nx);
        return ev;
    endfunction

    // Tick: accumulate time, then step once per whole duration of the frame
    // shown when the tick began. The walk through (frame, bounce, finished)
    // states repeats, so whole cycles of it are skipped once one is found.
    function automatic logic [7:0] advance_clock(input logic [15:0] delta);
        longint unsigned inc;
        longint unsigned total;
        longint unsigned step_len;
        longint unsigned left;
        longint unsigned steps;
        longint unsigned raw;
        longint unsigned per;
        int              key;
        bit              skipped;
        bit              visited    [STATE_KEYS];
        longint unsigned first_step [STATE_KEYS];
        longint unsigned first_raw  [STATE_KEYS];
        inc      = held ? 64'd0 : 64'(delta) * 64'(cfg_rate);
        total    = 64'(time_acc) + inc;
        if (total > 64'hFFFF_FFFF)
        begin
            total = 64'hFFFF_FFFF;
        end
        step_len = 64'(frame_len[shown_frame]) << 8;
        if (step_len == 0 || total < step_len)
        begin
            time_acc = 32'(total);
            return 8'd0;
        end
        left     = total / step_len;
        time_acc = 32'(total % step_len);
        steps    = 0;
        raw      = 0;
        skipped  = 1'b0;
        foreach (visited[k])
        begin
            visited[k] = 1'b0;
        end
        while (left > 0)
        begin
            key = int'(shown_frame) * 4 + int'(back_phase) * 2 + int'(at_end);
            if (!skipped)
            begin
                if (visited[key])
                begin
                    per     = steps - first_step[key];
                    raw    += (left / per) * (raw - first_raw[key]);
                    left    = left % per;
                    skipped = 1'b1;
                    if (left == 0)
                    begin
                        break;
                    end
                end
                else
                begin
                    visited[key]    = 1'b1;
                    first_step[key] = steps;
                    first_raw[key]  = raw;
                end
            end
            raw += 64'(step_one_frame());
            steps++;
            left--;
        end
        return (raw > 255) ? 8'd255 : 8'(raw);
    endfunction

    function automatic void jump_to(input int idx);
        if (idx >= frames_used())
        begin
            return;
        end
        time_acc    = '0;
        shown_frame = 6'(idx);
    endfunction

    // Display expected from one request word; updates the local state.
    function automatic sfs_result_t predict_display(input sfs_req_t w);
        sfs_result_t r;
        logic [5:0]  prior;
        logic [7:0]  ev;
        prior = shown_frame;
        ev    = 8'd0;
        case (w.req_type)
            REQ_TICK:
            begin
                ev = advance_clock(w.delta_time);
            end
            REQ_LOAD:
            begin
                frame_len[w.frame_index] = w.frame_duration;
            end
            REQ_SET_FRAME:
            begin
                jump_to(int'(w.frame_index));
            end
            REQ_RESET:
            begin
                back_phase = 1'b0;
                at_end     = 1'b0;
                if (cfg_reverse && frames_used() > 0)
                begin
                    jump_to(frames_used() - 1);
                end
                else
                begin
                    jump_to(0);
                end
                if (w.reset_mode == MODE_PLAY)
                begin
                    held = 1'b0;
                end
                else if (w.reset_mode == MODE_PAUSE)
                begin
                    held = 1'b1;
                end
            end
            REQ_PAUSE:
            begin
                if (held != w.pause_flag)
                begin
                    held = w.pause_flag;
                    if (!held)
                    begin
                        at_end = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.current_frame = shown_frame;
        r.finished      = at_end;
        r.bouncing      = back_phase;
        r.paused        = held;
        r.end_events    = ev;
        r.frame_changed = (shown_frame != prior);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: request words in bursts with random gaps. start may rise
    // while the block is busy; the word then waits for busy to drop.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : driver
        logic launch;
        if (!rst_n)
        begin
            start    <= 1'b0;
            req_word <= '0;
        end
        else
        begin
            launch = 1'b0;
            if (start && !busy)
            begin
                expected_displays.push_back(predict_display(req_word));
                words_sent++;
            end
            if (!start || !busy)
            begin
                if (burst_left == 0)
                begin
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                             : $urandom_range(1, 8);
                end
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (queued_words.size() != 0)
                begin
                    req_word <= queued_words.pop_front();
                    launch = 1'b1;
                    burst_left--;
                end
            end
            start <= launch || (start && busy);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: the result side cannot stall, so every strobe is taken.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        sfs_result_t want;
        if (rst_n && done)
        begin
            displays_seen++;
            events_total += int'(res_word.end_events);
            if (expected_displays.size() == 0)
            begin
                failures++;
                if (reports < REPORT_MAX)
                begin
                    $display("%0t: display with none expected, got %p", $time, res_word);
                end
                reports++;
            end
            else
            begin
                want = expected_displays.pop_front();
                if (res_word !== want)
                begin
                    failures++;
                    if (reports < REPORT_MAX)
                    begin
                        $display({"%0t: display mismatch: expected frame %0d fin %b bnc %b ",
                                  "pau %b ev %0d chg %b, got frame %0d fin %b bnc %b ",
                                  "pau %b ev %0d chg %b"}, $time,
                                 want.current_frame, want.finished, want.bouncing,
                                 want.paused, want.end_events, want.frame_changed,
                                 res_word.current_frame, res_word.finished,
                                 res_word.bouncing, res_word.paused,
                                 res_word.end_events, res_word.frame_changed);
                    end
                    reports++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: run exceeded %0d cycles, %0d displays still due", $time,
                     CYCLE_LIMIT, expected_displays.size());
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Mix of hold, short, medium and full-range durations.
    function automatic logic [23:0] pick_duration();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0)
        begin
            return 24'd0;
        end
        else if (sel < 4)
        begin
            return 24'($urandom_range(1, 64));
        end
        else if (sel < 6)
        begin
            return 24'($urandom_range(1, 8192));
        end
        return 24'($urandom);
    endfunction

    function automatic void queue_word(input logic [2:0] op, input logic [15:0] delta,
                                       input logic [5:0] idx, input logic [23:0] dur,
                                       input logic [1:0] mode, input logic flag);
        sfs_req_t w;
        w.req_type       = op;
        w.delta_time     = delta;
        w.frame_index    = idx;
        w.frame_duration = dur;
        w.reset_mode     = mode;
        w.pause_flag     = flag;
        queued_words.push_back(w);
    endfunction

    // Waits on the clock until nothing is queued, in flight or owed.
    task automatic wait_idle();
        do
            @(posedge clk);
        while (queued_words.size() != 0 || start || busy || expected_displays.size() != 0);
    endtask

    // One register word; must be entered right after the rising clock.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_NUM_FRAMES: cfg_frames = data[6:0];
            CFG_PLAY_RATE:  cfg_rate   = data;
            CFG_LOOP:
            begin
                cfg_loop = data[0];
                if (cfg_loop)
                begin
                    at_end = 1'b0;
                end
            end
            CFG_BOUNCE:     cfg_bounce  = data[0];
            CFG_REVERSE:    cfg_reverse = data[0];
            default:
            begin
            end
        endcase
    endtask

    // Unused upper data bits carry noise; the block must ignore them.
    task automatic write_settings(input int nf, input int rate, input logic lp,
                                  input logic bn, input logic rv);
        write_reg(CFG_NUM_FRAMES, {9'($urandom), 7'(nf)});
        write_reg(CFG_PLAY_RATE, 16'(rate));
        write_reg(CFG_LOOP, {15'($urandom), lp});
        write_reg(CFG_BOUNCE, {15'($urandom), bn});
        write_reg(CFG_REVERSE, {15'($urandom), rv});
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        sfs_req_t w;
        int       nf;
        int       rate;
        logic     lp;
        logic     bn;
        logic     rv;
        int       used;
        int       roll;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill the whole duration table first so no tick ever reads an
        // entry that was never loaded. Reset register values are in force.
        for (int i = 0; i < FRAME_SLOTS; i++)
        begin
            queue_word(REQ_LOAD, 16'($urandom), 6'(i), pick_duration(), 2'($urandom),
                       1'($urandom));
        end
        for (int i = 0; i < 3; i++)
        begin
            queue_word(REQ_TICK, 16'($urandom), 6'($urandom), 24'($urandom),
                       2'($urandom), 1'($urandom));
        end
        wait_idle();

        // Directed: four frames, top play rate, one-shot forward playback.
        write_settings(4, 16'hFFFF, 1'b0, 1'b0, 1'b0);
        queue_word(REQ_LOAD, '0, 6'd63, 24'hFF_FFFF, MODE_KEEP, 1'b0);
        queue_word(REQ_LOAD, '0, 6'd0, 24'hFF_FFFF, MODE_KEEP, 1'b0);
        queue_word(REQ_LOAD, '0, 6'd1, 24'd1, MODE_KEEP, 1'b0);
        queue_word(REQ_LOAD, '0, 6'd2, 24'd2, MODE_KEEP, 1'b0);
        queue_word(REQ_LOAD, '0, 6'd3, 24'd0, MODE_KEEP, 1'b0);
        queue_word(REQ_RESET, '0, '0, '0, MODE_PLAY, 1'b0);
        // two full-scale ticks: the second saturates the elapsed time
        queue_word(REQ_TICK, 16'hFFFF, '0, '0, MODE_KEEP, 1'b0);
        queue_word(REQ_TICK, 16'hFFFF, '0, '0, MODE_KEEP, 1'b0);
        queue_word(REQ_TICK, 16'h0000, '0, '0, MODE_KEEP, 1'b0);
        // hundreds of steps in one tick run off the end and finish
        queue_word(REQ_TICK, 16'h0001, '0, '0, MODE_KEEP, 1'b0);
        // zero duration on the last frame holds it
        queue_word(REQ_TICK, 16'h0001, '0, '0, MODE_KEEP, 1'b0);
        queue_word(REQ_PAUSE, '0, '0, '0, MODE_KEEP, 1'b1);
        // resume clears the finished mark
        queue_word(REQ_PAUSE, '0, '0, '0, MODE_KEEP, 1'b0);
        queue_word(REQ_SET_FRAME, '0, 6'd63, '0, MODE_KEEP, 1'b0);
        queue_word(REQ_SET_FRAME, '0, 6'd0, '0, MODE_KEEP, 1'b0);
        queue_word(REQ_TICK, 16'd1000, '0, '0, MODE_KEEP, 1'b0);
        // paused tick still steps once the duration shrinks below elapsed
        queue_word(REQ_PAUSE, '0, '0, '0, MODE_KEEP, 1'b1);
        queue_word(REQ_LOAD, '0, 6'd0, 24'd1, MODE_KEEP, 1'b0);
        queue_word(REQ_TICK, 16'hFFFF, '0, '0, MODE_KEEP, 1'b0);
        queue_word(REQ_PAUSE, '0, '0, '0, MODE_KEEP, 1'b1);
        queue_word(REQ_RESET, '0, '0, '0, MODE_KEEP, 1'b0);
        queue_word(REQ_RESET, '0, '0, '0, MODE_SPARE, 1'b0);
        queue_word(REQ_RESET, '0, '0, '0, MODE_PAUSE, 1'b0);
        queue_word(REQ_RESET, '0, '0, '0, MODE_PLAY, 1'b0);
        for (int c = int'(REQ_PAUSE) + 1; c < REQ_CODES; c++)
        begin
            queue_word(3'(c), 16'hFFFF, 6'd63, 24'hFF_FFFF, MODE_SPARE, 1'b1);
        end
        wait_idle();

        // Random phases, one register setting each.
        for (int p = 0; p < SETTING_COUNT; p++)
        begin
            case (p)
                0:  begin nf = 4;   rate = 256;   lp = 0; bn = 0; rv = 0; end
                1:  begin nf = 8;   rate = 256;   lp = 1; bn = 0; rv = 0; end
                2:  begin nf = 6;   rate = 512;   lp = 1; bn = 1; rv = 0; end
                3:  begin nf = 5;   rate = 128;   lp = 0; bn = 1; rv = 1; end
                4:  begin nf = 7;   rate = 300;   lp = 1; bn = 0; rv = 1; end
                5:  begin nf = 64;  rate = 65535; lp = 1; bn = 1; rv = 1; end
                6:  begin nf = 0;   rate = 0;     lp = 0; bn = 0; rv = 0; end
                7:  begin nf = 1;   rate = 256;   lp = 1; bn = 1; rv = 0; end
                8:  begin nf = 2;   rate = 1000;  lp = 0; bn = 1; rv = 1; end
                9:  begin nf = 100; rate = 256;   lp = 0; bn = 0; rv = 1; end
                10: begin nf = 64;  rate = 256;   lp = 0; bn = 1; rv = 0; end
                default:
                begin
                    nf   = $urandom_range(0, 16);
                    rate = $urandom_range(0, 2048);
                    lp   = 1'($urandom);
                    bn   = 1'($urandom);
                    rv   = 1'($urandom);
                end
            endcase
            write_settings(nf, rate, lp, bn, rv);
            used = (nf < FRAME_SLOTS) ? nf : FRAME_SLOTS;

            for (int n = 0; n < WORDS_PER_SETTING; n++)
            begin
                // every field random; the chosen request shapes its own
                w.delta_time     = 16'($urandom);
                w.frame_index    = 6'($urandom);
                w.frame_duration = 24'($urandom);
                w.reset_mode     = 2'($urandom);
                w.pause_flag     = 1'($urandom);
                roll             = $urandom_range(0, 99);
                if (roll < 58)
                begin
                    w.req_type = REQ_TICK;
                    case ($urandom_range(0, 3))
                        0: w.delta_time = 16'($urandom_range(0, 255));
                        1: w.delta_time = 16'($urandom_range(0, 4095));
                        2: w.delta_time = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
                        default:
                        begin
                        end
                    endcase
                end
                else if (roll < 68)
                begin
                    w.req_type       = REQ_LOAD;
                    w.frame_duration = pick_duration();
                    if (used > 0 && $urandom_range(0, 3) != 0)
                    begin
                        w.frame_index = 6'($urandom_range(0, used - 1));
                    end
                end
                else if (roll < 78)
                begin
                    w.req_type = REQ_SET_FRAME;
                    if (used > 0 && $urandom_range(0, 4) != 0)
                    begin
                        w.frame_index = 6'($urandom_range(0, used - 1));
                    end
                end
                else if (roll < 84)
                begin
                    w.req_type = REQ_RESET;
                end
                else if (roll < 95)
                begin
                    // mostly resume, so ticks keep moving time on
                    w.req_type   = REQ_PAUSE;
                    w.pause_flag = ($urandom_range(0, 2) == 0);
                end
                else
                begin
                    w.req_type = 3'($urandom_range(int'(REQ_PAUSE) + 1, REQ_CODES - 1));
                end
                queued_words.push_back(w);
            end
            wait_idle();
        end

        // room for any stray strobe after the last display
        repeat (64) @(posedge clk);
        failures += expected_displays.size();
        $display("ran %0d words under %0d register settings; %0d displays checked,",
                 words_sent, settings_used, displays_seen);
        $display("%0d end events seen, %0d failures", events_total, failures);
        if (failures == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
